// ===== rtl/assert_macros.svh =====
// Assertion macros used by the polar_vector_add top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PVA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PVA_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PVA_ASSERT(lbl, clk, rst, prop, msg)
`define PVA_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ===== rtl/pva_pkg.sv =====
// Widths, limits and shared types of the polar vector adder
`timescale 1ns / 1ps
package pva_pkg;
  localparam int RADIUS_W = 32;
  localparam int DIR_W = 16;
  localparam int THR_W = 16;
  localparam int RADIUS_FRAC_BITS = 16;
  localparam int DIR_FRAC_BITS = 14;
  // signed product of a zero-extended radius and a direction
  localparam int PROD_W = RADIUS_W + DIR_W + 1;
  localparam int MAG_W = PROD_W;
  localparam int AX_W = MAG_W - DIR_FRAC_BITS;
  localparam int SQ_W = 2 * AX_W + 1;
  localparam int ROOT_W = (SQ_W + 1) / 2;
  localparam int QUO_W = DIR_FRAC_BITS + 1;
  localparam int DVW = ROOT_W + QUO_W;
  localparam int DIR_LIMIT = ((1 << DIR_FRAC_BITS) > 32767) ? 32767 : (1 << DIR_FRAC_BITS);

  typedef struct packed {
    logic [RADIUS_W-1:0] a_radius;
    logic signed [DIR_W-1:0] a_dir_x;
    logic signed [DIR_W-1:0] a_dir_y;
    logic [RADIUS_W-1:0] b_radius;
    logic signed [DIR_W-1:0] b_dir_x;
    logic signed [DIR_W-1:0] b_dir_y;
  } pva_in_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic neg_x;
    logic neg_y;
  } pva_side_t;

  typedef struct packed {
    logic [ROOT_W-1:0] radius;
    logic [QUO_W-1:0] q_x;
    logic [QUO_W-1:0] q_y;
    logic ov_x;
    logic ov_y;
    logic neg_x;
    logic neg_y;
  } pva_div_t;
endpackage

// ===== rtl/pva_if.sv =====
// Stream and configuration channel interfaces
`timescale 1ns / 1ps
interface pva_in_if;
  logic valid;
  logic ready;
  logic [31:0] a_radius;
  logic signed [15:0] a_dir_x;
  logic signed [15:0] a_dir_y;
  logic [31:0] b_radius;
  logic signed [15:0] b_dir_x;
  logic signed [15:0] b_dir_y;
  modport source(output valid, a_radius, a_dir_x, a_dir_y, b_radius, b_dir_x, b_dir_y,
                 input ready);
  modport sink(input valid, a_radius, a_dir_x, a_dir_y, b_radius, b_dir_x, b_dir_y,
               output ready);
endinterface

interface pva_out_if;
  logic valid;
  logic ready;
  logic [31:0] sum_radius;
  logic signed [15:0] sum_dir_x;
  logic signed [15:0] sum_dir_y;
  logic radius_saturated;
  modport source(output valid, sum_radius, sum_dir_x, sum_dir_y, radius_saturated,
                 input ready);
  modport sink(input valid, sum_radius, sum_dir_x, sum_dir_y, radius_saturated,
               output ready);
endinterface

interface pva_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] zero_threshold;
  modport source(output valid, zero_threshold, input ready);
  modport sink(input valid, zero_threshold, output ready);
endinterface

// ===== rtl/pva_cart.sv =====
// Cartesian sum, magnitudes and sum of squares: four register stages
`timescale 1ns / 1ps
module pva_cart
  import pva_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  pva_in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output logic [SQ_W-1:0] out_sq,
  output pva_side_t out_side
);
  logic [3:0] v;
  logic [4:0] en;
  logic signed [PROD_W-1:0] p_ax, p_ay, p_bx, p_by;
  logic signed [PROD_W:0] x_sum, y_sum;
  logic [PROD_W:0] x_abs, y_abs;
  pva_side_t side1, side2, side3;
  logic [2*AX_W-1:0] sq_x, sq_y;
  logic [SQ_W-1:0] sq;
  logic [AX_W-1:0] ax, ay;

  assign en[4] = out_ready;
  assign en[3] = !v[3] || en[4];
  assign en[2] = !v[2] || en[3];
  assign en[1] = !v[1] || en[2];
  assign en[0] = !v[0] || en[1];
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
    end
  end

  assign x_sum = {p_ax[PROD_W-1], p_ax} + {p_bx[PROD_W-1], p_bx};
  assign y_sum = {p_ay[PROD_W-1], p_ay} + {p_by[PROD_W-1], p_by};
  assign x_abs = x_sum[PROD_W] ? (~x_sum + 1'b1) : x_sum;
  assign y_abs = y_sum[PROD_W] ? (~y_sum + 1'b1) : y_sum;
  assign ax = side1.mag_x[MAG_W-1:DIR_FRAC_BITS];
  assign ay = side1.mag_y[MAG_W-1:DIR_FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_ax <= $signed({1'b0, in_data.a_radius}) * in_data.a_dir_x;
      p_ay <= $signed({1'b0, in_data.a_radius}) * in_data.a_dir_y;
      p_bx <= $signed({1'b0, in_data.b_radius}) * in_data.b_dir_x;
      p_by <= $signed({1'b0, in_data.b_radius}) * in_data.b_dir_y;
    end
    if (en[1]) begin
      side1.mag_x <= x_abs[MAG_W-1:0];
      side1.mag_y <= y_abs[MAG_W-1:0];
      side1.neg_x <= x_sum[PROD_W];
      side1.neg_y <= y_sum[PROD_W];
    end
    if (en[2]) begin
      sq_x <= ax * ax;
      sq_y <= ay * ay;
      side2 <= side1;
    end
    if (en[3]) begin
      sq <= {1'b0, sq_x} + {1'b0, sq_y};
      side3 <= side2;
    end
  end

  assign out_valid = v[3];
  assign out_sq = sq;
  assign out_side = side3;
endmodule

// ===== rtl/pva_sqrt.sv =====
// Pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module pva_sqrt
  import pva_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [SQ_W-1:0] in_sq,
  input  pva_side_t in_side,
  output logic out_valid,
  input  logic out_ready,
  output logic [ROOT_W-1:0] out_root,
  output pva_side_t out_side
);
  localparam int REM_W = ROOT_W + 2;
  localparam int OPND_W = 2 * ROOT_W;

  logic v_q [ROOT_W];
  logic [REM_W-1:0] rem_q [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [OPND_W-1:0] op_q [ROOT_W];
  pva_side_t side_q [ROOT_W];
  logic [ROOT_W:0] en;

  assign en[ROOT_W] = out_ready;
  assign in_ready = en[0];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic v_in;
    logic [REM_W-1:0] rem_in, rem_sh, trial;
    logic [ROOT_W-1:0] root_in;
    logic [OPND_W-1:0] op_in;
    pva_side_t side_in;
    logic take;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign rem_in = '0;
      assign root_in = '0;
      assign op_in = OPND_W'(in_sq);
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign op_in = op_q[k-1];
      assign side_in = side_q[k-1];
    end

    // next two operand bits enter the partial remainder
    assign rem_sh = {rem_in[REM_W-3:0], op_in[2*(ROOT_W-1-k)+1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign take = rem_sh >= trial;
    assign en[k] = !v_q[k] || en[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_q[k] <= take ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[ROOT_W-2:0], take};
        op_q[k] <= op_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign out_valid = v_q[ROOT_W-1];
  assign out_root = root_q[ROOT_W-1];
  assign out_side = side_q[ROOT_W-1];
endmodule

// ===== rtl/pva_div.sv =====
// Pipelined restoring divider: both direction magnitudes over the radius
`timescale 1ns / 1ps
module pva_div
  import pva_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [ROOT_W-1:0] in_root,
  input  pva_side_t in_side,
  output logic out_valid,
  input  logic out_ready,
  output pva_div_t out_data
);
  localparam int NS = QUO_W + 1;

  logic v_q [NS];
  logic [MAG_W-1:0] rx_q [NS];
  logic [MAG_W-1:0] ry_q [NS];
  pva_div_t d_q [NS];
  logic [NS:0] en;

  assign en[NS] = out_ready;
  assign in_ready = en[0];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic v_in;
    logic [MAG_W-1:0] rx_next, ry_next;
    pva_div_t d_next;

    if (s == 0) begin : g_first
      logic [DVW-1:0] dtop;
      assign dtop = DVW'(in_root) << QUO_W;
      assign v_in = in_valid;
      assign rx_next = in_side.mag_x;
      assign ry_next = in_side.mag_y;
      always_comb begin
        d_next.radius = in_root;
        d_next.q_x = '0;
        d_next.q_y = '0;
        // quotient too large for the bit stages: clamped later
        d_next.ov_x = DVW'(in_side.mag_x) >= dtop;
        d_next.ov_y = DVW'(in_side.mag_y) >= dtop;
        d_next.neg_x = in_side.neg_x;
        d_next.neg_y = in_side.neg_y;
      end
    end else begin : g_rest
      logic [DVW-1:0] dsh;
      logic tx, ty;
      assign dsh = DVW'(d_q[s-1].radius) << (QUO_W - s);
      assign tx = DVW'(rx_q[s-1]) >= dsh;
      assign ty = DVW'(ry_q[s-1]) >= dsh;
      assign v_in = v_q[s-1];
      assign rx_next = tx ? MAG_W'(DVW'(rx_q[s-1]) - dsh) : rx_q[s-1];
      assign ry_next = ty ? MAG_W'(DVW'(ry_q[s-1]) - dsh) : ry_q[s-1];
      always_comb begin
        d_next = d_q[s-1];
        d_next.q_x[QUO_W-s] = tx;
        d_next.q_y[QUO_W-s] = ty;
      end
    end

    assign en[s] = !v_q[s] || en[s+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rx_q[s] <= rx_next;
        ry_q[s] <= ry_next;
        d_q[s] <= d_next;
      end
    end
  end

  assign out_valid = v_q[NS-1];
  assign out_data = d_q[NS-1];
endmodule

// ===== rtl/polar_vector_add.sv =====
// An accepted input beat passes the pva_cart, pva_sqrt and pva_div stages and the output register.
// Throughput: one beat per cycle while results are taken; every stage holds its own valid bit, so a
// stalled result lets earlier stages keep filling bubbles.
// The square root (one bit per stage) and divider (overflow check, then one quotient bit per stage) set the depth.
// Synchronous active-high reset empties the pipeline and sets zero_threshold to 1.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module polar_vector_add
  import pva_pkg::*;
(
  input logic clk,
  input logic rst,
  pva_in_if.sink items,
  pva_out_if.source results,
  pva_cfg_if.sink cfg
);
  logic [THR_W-1:0] zero_threshold;
  pva_in_t in_data;
  logic c_valid, c_ready, s_valid, s_ready, d_valid, d_ready;
  logic [SQ_W-1:0] c_sq;
  pva_side_t c_side, s_side;
  logic [ROOT_W-1:0] s_root;
  pva_div_t d_data;
  logic o_valid, o_en, degen, sat;
  logic [QUO_W-1:0] qx, qy;
  logic [DIR_W-1:0] dx, dy;
  logic [RADIUS_W-1:0] o_radius;
  logic [DIR_W-1:0] o_dir_x, o_dir_y;
  logic o_sat;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_threshold <= THR_W'(1);
    end else if (cfg.valid) begin
      zero_threshold <= cfg.zero_threshold;
    end
  end

  always_comb begin
    in_data.a_radius = items.a_radius;
    in_data.a_dir_x = items.a_dir_x;
    in_data.a_dir_y = items.a_dir_y;
    in_data.b_radius = items.b_radius;
    in_data.b_dir_x = items.b_dir_x;
    in_data.b_dir_y = items.b_dir_y;
  end

  pva_cart u_cart (
    .clk, .rst,
    .in_valid(items.valid), .in_ready(items.ready), .in_data,
    .out_valid(c_valid), .out_ready(c_ready), .out_sq(c_sq), .out_side(c_side)
  );

  pva_sqrt u_sqrt (
    .clk, .rst,
    .in_valid(c_valid), .in_ready(c_ready), .in_sq(c_sq), .in_side(c_side),
    .out_valid(s_valid), .out_ready(s_ready), .out_root(s_root), .out_side(s_side)
  );

  pva_div u_div (
    .clk, .rst,
    .in_valid(s_valid), .in_ready(s_ready), .in_root(s_root), .in_side(s_side),
    .out_valid(d_valid), .out_ready(d_ready), .out_data(d_data)
  );

  assign o_en = !o_valid || results.ready;
  assign d_ready = o_en;

  assign degen = d_data.radius <= ROOT_W'(zero_threshold);
  assign sat = |d_data.radius[ROOT_W-1:RADIUS_W];
  assign qx = (d_data.ov_x || d_data.q_x > QUO_W'(DIR_LIMIT)) ? QUO_W'(DIR_LIMIT) : d_data.q_x;
  assign qy = (d_data.ov_y || d_data.q_y > QUO_W'(DIR_LIMIT)) ? QUO_W'(DIR_LIMIT) : d_data.q_y;
  assign dx = d_data.neg_x ? (~DIR_W'(qx) + 1'b1) : DIR_W'(qx);
  assign dy = d_data.neg_y ? (~DIR_W'(qy) + 1'b1) : DIR_W'(qy);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_en) begin
      o_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      o_radius <= degen ? '0 : (sat ? '1 : d_data.radius[RADIUS_W-1:0]);
      o_dir_x <= degen ? '0 : dx;
      o_dir_y <= degen ? '0 : dy;
      o_sat <= !degen && sat;
    end
  end

  assign results.valid = o_valid;
  assign results.sum_radius = o_radius;
  assign results.sum_dir_x = o_dir_x;
  assign results.sum_dir_y = o_dir_y;
  assign results.radius_saturated = o_sat;

  `PVA_ASSERT(a_zero_dir, clk, rst, results.valid && results.sum_radius == '0 |-> results.sum_dir_x == '0 && results.sum_dir_y == '0, "zero radius with nonzero direction")
  `PVA_ASSERT(a_sat_max, clk, rst, results.valid && results.radius_saturated |-> results.sum_radius == '1, "saturation flag without full-scale radius")
  `PVA_ASSERT(a_dir_range, clk, rst, results.valid |-> $signed(results.sum_dir_x) <= DIR_LIMIT && $signed(results.sum_dir_x) >= -DIR_LIMIT && $signed(results.sum_dir_y) <= DIR_LIMIT && $signed(results.sum_dir_y) >= -DIR_LIMIT, "direction beyond unit limit")
  `PVA_NEVER(a_stall_full, clk, rst, !items.ready && !results.valid, "input stalled while output empty")
endmodule

// ===== sim/tb_if.sv =====
// Testbench package: expected result record
`timescale 1ns / 1ps
package pva_tb_pkg;
  typedef struct {
    logic [31:0] radius;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic sat;
  } sum_vec_t;
endpackage

// ===== sim/testbench.sv =====
// Stream testbench for polar_vector_add: random vector pairs checked against a local predictor
`timescale 1ns / 1ps
module testbench;
  import pva_pkg::*;
  import pva_tb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  pva_in_if items();
  pva_out_if results();
  pva_cfg_if cfg();

  polar_vector_add dut(.clk(clk), .rst(rst), .items(items), .results(results), .cfg(cfg));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  pva_in_t pending_pairs[$];
  sum_vec_t expected_sums[$];
  logic [15:0] threshold = 16'd1;
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  logic [15:0] pending_thr;
  logic thr_req = 0;

  function automatic logic [127:0] isqrt(logic [127:0] v);
    logic [127:0] res, cand;
    res = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (128'd1 << b);
      if (cand * cand <= v) res = cand;
    end
    return res;
  endfunction

  function automatic logic [15:0] dir_of(logic signed [63:0] c, logic [127:0] r);
    logic [127:0] m, q;
    m = c < 0 ? -c : c;
    q = m / r;
    if (q > (1 << DIR_FRAC_BITS)) q = 1 << DIR_FRAC_BITS;
    if (c < 0) q = -q;
    return q[15:0];
  endfunction

  function automatic sum_vec_t predict_sum(pva_in_t p);
    logic signed [63:0] x, y;
    logic [127:0] ax, ay, r;
    sum_vec_t s;
    x = $signed({32'd0, p.a_radius}) * p.a_dir_x + $signed({32'd0, p.b_radius}) * p.b_dir_x;
    y = $signed({32'd0, p.a_radius}) * p.a_dir_y + $signed({32'd0, p.b_radius}) * p.b_dir_y;
    ax = (x < 0 ? -x : x) >> DIR_FRAC_BITS;
    ay = (y < 0 ? -y : y) >> DIR_FRAC_BITS;
    r = isqrt(ax * ax + ay * ay);
    s = '{32'd0, 16'sd0, 16'sd0, 1'b0};
    if (r > threshold) begin
      s.sat = r > 128'hFFFFFFFF;
      s.radius = s.sat ? 32'hFFFFFFFF : r[31:0];
      s.dir_x = dir_of(x, r);
      s.dir_y = dir_of(y, r);
    end
    return s;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      items.valid <= 0;
      cfg.valid <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        threshold = cfg.zero_threshold;
        thr_req = 0;
      end
      cfg.valid <= thr_req && !(cfg.valid && cfg.ready);
      cfg.zero_threshold <= pending_thr;
      if (items.valid && items.ready) begin
        expected_sums.push_back(predict_sum(pending_pairs.pop_front()));
      end
      // a waiting beat stays on the bus until taken
      if (!(items.valid && !items.ready)) begin
        if (pending_pairs.size() > 0 && !thr_req && $urandom_range(99) >= send_idle) begin
          items.valid <= 1;
          {items.a_radius, items.a_dir_x, items.a_dir_y,
           items.b_radius, items.b_dir_x, items.b_dir_y} <= pending_pairs[0];
        end else
          items.valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) results.ready <= 0;
    else begin
      if (results.valid && results.ready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, results.sum_radius);
          errors++;
        end else begin
          sum_vec_t e;
          e = expected_sums.pop_front();
          if (e.radius !== results.sum_radius || e.dir_x !== results.sum_dir_x ||
              e.dir_y !== results.sum_dir_y || e.sat !== results.radius_saturated) begin
            $display("%0t: expected %h %h %h %b got %h %h %h %b", $time,
                     e.radius, e.dir_x, e.dir_y, e.sat, results.sum_radius,
                     results.sum_dir_x, results.sum_dir_y, results.radius_saturated);
            errors++;
          end
        end
      end
      results.ready <= $urandom_range(99) >= recv_idle;
    end
  end

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3: return 16'($urandom);
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] rand_radius();
    case ($urandom_range(4))
      0: return 32'hFFFFFFFF - $urandom_range(3);
      1: return $urandom_range(8);
      2: return $urandom_range(65535);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_idle();
    while (pending_pairs.size() > 0 || expected_sums.size() > 0 || items.valid)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_threshold(logic [15:0] v);
    pending_thr = v;
    thr_req = 1;
    while (thr_req) @(posedge clk);
  endtask

  initial begin
    pva_in_t p;
    items.valid = 0;
    items.a_radius = 0; items.a_dir_x = 0; items.a_dir_y = 0;
    items.b_radius = 0; items.b_dir_x = 0; items.b_dir_y = 0;
    results.ready = 0;
    cfg.valid = 0;
    cfg.zero_threshold = 0;
    pending_thr = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    // directed: extremes, cancellation, overflow, non-unit directions
    pending_pairs.push_back('{32'hFFFFFFFF, 16'sd16384, 0, 32'hFFFFFFFF, 16'sd16384, 0});
    pending_pairs.push_back('{32'hFFFFFFFF, 16'h8000, 16'h8000, 32'hFFFFFFFF, 16'h8000, 16'h8000});
    pending_pairs.push_back('{32'hFFFFFFFF, 16'h7FFF, 16'h7FFF, 32'hFFFFFFFF, 16'h7FFF, 16'h7FFF});
    pending_pairs.push_back('{32'h10000, 16'sd16384, 0, 32'h10000, -16'sd16384, 0});
    pending_pairs.push_back('{0, 0, 0, 0, 0, 0});
    pending_pairs.push_back('{1, 16'sd16384, 0, 1, 0, 16'sd16384});
    pending_pairs.push_back('{2, 16'sd16384, 0, 0, 0, 0});
    pending_pairs.push_back('{32'h30000, 16'sd11585, 16'sd11585, 32'h10000, 0, -16'sd16384});
    pending_pairs.push_back('{32'h12345, -16'sd9830, 16'sd13107, 32'h54321, 16'sd13107, -16'sd9830});
    pending_pairs.push_back('{32'hFFFF, 16'sd16383, 16'sd181, 0, 0, 0});
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin send_idle = 20; recv_idle = 82; end
        1: begin send_idle = 82; recv_idle = 20; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      wait_idle();
      case (phase)
        0: set_threshold(16'd0);
        1: set_threshold(16'hFFFF);
        2: set_threshold(16'd1);
        default: set_threshold(16'($urandom));
      endcase
      for (int i = 0; i < 285; i++) begin
        p.a_radius = rand_radius(); p.b_radius = rand_radius();
        p.a_dir_x = rand_dir(); p.a_dir_y = rand_dir();
        p.b_dir_x = rand_dir(); p.b_dir_y = rand_dir();
        // near cancellation now and then
        if ($urandom_range(7) == 0) begin
          p.b_radius = p.a_radius + $urandom_range(4) - 2;
          p.b_dir_x = -p.a_dir_x; p.b_dir_y = -p.a_dir_y;
        end
        pending_pairs.push_back(p);
      end
    end
    wait_idle();
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pva_pkg.sv
rtl/pva_if.sv
rtl/pva_cart.sv
rtl/pva_sqrt.sv
rtl/pva_div.sv
rtl/polar_vector_add.sv
sim/tb_if.sv
sim/testbench.sv
